>>> design/sapq_pkg.sv
// Shared types and codes for the sorted-array priority queue.
package sapq_pkg;

	// Default sizes of the queue.
	localparam int DEPTH_DEF = 8;
	localparam int PRIO_BITS_DEF = 8;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Operation selector carried with each input item.
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// Result status carried with each result item.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

>>> design/sapq_cell.sv
// One slot of the sorted chain: holds a priority and a payload word.
module sapq_cell #(
	parameter int PRIO_BITS = sapq_pkg::PRIO_BITS_DEF,
	parameter int PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS_DEF,
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                    clk,
	input  sapq_pkg::cell_ctl_t     ctl,
	input  logic [PRIO_BITS-1:0]    new_prio,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    occ,
	input  logic                    left_occ,
	input  logic                    left_gt,
	input  logic [PRIO_BITS-1:0]    left_prio,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [PRIO_BITS-1:0]    right_prio,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    gt,
	output logic [PRIO_BITS-1:0]    prio,
	output logic [PAYLOAD_BITS-1:0] payload
);

	logic [PRIO_BITS-1:0]    prio_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    take_new;

	// This slot holds an entry that must move behind the new one.
	assign gt = occ && (prio_q > new_prio);

	// The new entry lands here when everything to the left stays put and this
	// slot is either free at the tail or holds a larger priority.
	assign take_new = !left_gt && (gt || !occ) && (IS_HEAD || left_occ);

	// Shift right on insert, shift left on remove, otherwise hold.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				prio_q    <= left_prio;
				payload_q <= left_payload;
			end else if (take_new) begin
				prio_q    <= new_prio;
				payload_q <= new_payload;
			end
		end else if (ctl.rem) begin
			prio_q    <= right_prio;
			payload_q <= right_payload;
		end
	end

	assign prio = prio_q;
	assign payload = payload_q;

endmodule

>>> design/sorted_array_priority_queue_core.sv
// A result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle while the result side takes items every cycle;
// the chain of slot cells updates all slots in parallel.
// A single output register parts the two sides; s_tready drops only while it
// holds an untaken result. Reset empties the queue and clears the output valid;
// slot contents are not reset and are written before they are ever read.
module sorted_array_priority_queue_core #(
	parameter int DEPTH = sapq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = sapq_pkg::PRIO_BITS_DEF,
	parameter int PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int S_W = ((PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8,
	localparam int M_W = ((PRIO_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// Fields from bit 0 up: priority_req, payload, zero fill.
	input  logic [S_W-1:0] s_tdata,
	// Fields from bit 0 up: operation.
	input  logic           s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	// Fields from bit 0 up: out_priority, out_payload, occupancy, zero fill.
	output logic [M_W-1:0] m_tdata,
	// Fields from bit 0 up: status.
	output logic [1:0]     m_tuser
);

	logic [PRIO_BITS-1:0]    in_prio;
	logic [PAYLOAD_BITS-1:0] in_payload;
	logic                    accept;
	logic                    is_enq;
	logic                    full;
	logic                    empty;
	logic [CNT_W-1:0]        count_q;
	logic [DEPTH-1:0]        occ;
	logic [DEPTH-1:0]        gt_w;
	logic [PRIO_BITS-1:0]    prio_w [DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_w [DEPTH];
	sapq_pkg::cell_ctl_t     ctl;
	sapq_pkg::status_t       status_d;
	logic                    out_valid_q;
	logic [M_W-1:0]          out_data_q;
	sapq_pkg::status_t       out_status_q;
	logic [PRIO_BITS-1:0]    res_prio;
	logic [PAYLOAD_BITS-1:0] res_payload;

	assign in_prio    = s_tdata[PRIO_BITS-1:0];
	assign in_payload = s_tdata[PRIO_BITS +: PAYLOAD_BITS];
	assign is_enq     = (sapq_pkg::op_t'(s_tuser) == sapq_pkg::OP_ENQ);

	// Accept whenever the output register is free or being emptied.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign ctl.ins = accept && is_enq && !full;
	assign ctl.rem = accept && !is_enq && !empty;

	// Occupied flags derived from the fill count.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (CNT_W'(i) < count_q);
		end
	end

	// The chain of slot cells; the head sits at index 0.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sapq_cell #(
			.PRIO_BITS    (PRIO_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.IS_HEAD      (i == 0)
		) u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.new_prio      (in_prio),
			.new_payload   (in_payload),
			.occ           (occ[i]),
			.left_occ      ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1]),
			.left_gt       ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i - 1]),
			.left_prio     (prio_w[(i == 0) ? 0 : i - 1]),
			.left_payload  (payload_w[(i == 0) ? 0 : i - 1]),
			.right_prio    (prio_w[(i == DEPTH - 1) ? i : i + 1]),
			.right_payload (payload_w[(i == DEPTH - 1) ? i : i + 1]),
			.gt            (gt_w[i]),
			.prio          (prio_w[i]),
			.payload       (payload_w[i])
		);
	end

	// Fill count tracks the number of held entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Result status and dequeued entry for the accepted item.
	always_comb begin
		status_d    = sapq_pkg::ST_DONE;
		res_prio    = '0;
		res_payload = '0;
		if (is_enq) begin
			if (full) begin
				status_d = sapq_pkg::ST_FULL;
			end
		end else if (empty) begin
			status_d = sapq_pkg::ST_EMPTY;
		end else begin
			res_prio    = prio_w[0];
			res_payload = payload_w[0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Output register payload, loaded with each accepted item's result.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_d;
			out_data_q   <= M_W'({
				ctl.ins ? count_q + CNT_W'(1) : (ctl.rem ? count_q - CNT_W'(1) : count_q),
				res_payload, res_prio});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule

>>> design/sapq_checker.sv
// Port-level checker for the sorted-array priority queue, bound to the top level.
module sapq_checker #(
	parameter int DEPTH = sapq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = sapq_pkg::PRIO_BITS_DEF,
	parameter int PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int M_W = ((PRIO_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata,
	input logic [1:0]     m_tuser
);

	logic [CNT_W-1:0]                     occ;
	logic [PRIO_BITS+PAYLOAD_BITS-1:0]    entry;

	assign occ   = m_tdata[PRIO_BITS + PAYLOAD_BITS +: CNT_W];
	assign entry = m_tdata[PRIO_BITS + PAYLOAD_BITS - 1:0];

	// An empty report always comes with zero occupancy.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sapq_pkg::ST_EMPTY) |-> (occ == '0))
		else $error("empty status with nonzero occupancy");

	// A full report always comes with the queue at its depth.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sapq_pkg::ST_FULL) |-> (occ == CNT_W'(DEPTH)))
		else $error("full status with occupancy below depth");

	// A refused or empty operation returns a zero entry.
	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != sapq_pkg::ST_DONE) |-> (entry == '0))
		else $error("nonzero entry on a failed operation");

	// A stalled result holds its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind sorted_array_priority_queue_core sapq_checker #(
	.DEPTH        (DEPTH),
	.PRIO_BITS    (PRIO_BITS),
	.PAYLOAD_BITS (PAYLOAD_BITS)
) u_sapq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
